FILE: rtl/pbpd_pkg.sv
// Package for the page buffer pool directory: command codes, status codes,
// result type and the controller/datapath command and status structs.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pbpd_pkg;
	localparam int FRAMES_MAX = 64;
	localparam int FRAMES_DEF = 64;
	localparam int FRAME_W = 6;
	localparam int PAGE_W = 32;
	localparam int PIN_W = 16;
	localparam int STAMP_W = 64;

	localparam logic [2:0] CMD_GET = 3'd0;
	localparam logic [2:0] CMD_GET_WR = 3'd1;
	localparam logic [2:0] CMD_UNPIN = 3'd2;
	localparam logic [2:0] CMD_FLUSH = 3'd3;
	localparam logic [2:0] CMD_DISCARD = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_NOT_RESIDENT = 2'd2;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] page;
	} req_t;

	typedef struct packed {
		logic [5:0]  frame;
		logic        hit;
		logic [1:0]  status;
		logic        fetch;
		logic        writeback;
		logic [31:0] writeback_page;
		logic        journal;
		logic        last;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic search;      // register the first half of the victim search
		logic resolve;     // register lookup and final victim results
		logic do_get;      // commit a get
		logic do_unpin;    // commit an unpin
		logic do_discard;  // invalidate all frames
		logic flush_step;  // clear dirty bit of the frame under the flush cursor
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic found;
		logic victim_ok;
		logic flush_any;   // a dirty valid frame remains
		logic flush_more;  // another one after the current
	} dp_sts_t;
endpackage
`default_nettype wire

FILE: rtl/pbpd_if.sv
// Valid/ready channel interface carrying one payload item.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface pbpd_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/page_buffer_pool_directory_top.sv
// Top level of the page buffer pool directory.
// Depends on pbpd_pkg, pbpd_if, pbpd_ctrl and pbpd_datapath.
//
//   Port            Direction  Carries
//   cmd_in          sink       command, page
//   res_out         source     frame, hit, status, fetch, writeback,
//                              writeback_page, journal, last
//   journal_we/wd   input      journal_enable register write
//
// A get, unpin, discard or unknown command passes through the search, resolve
// and exec states (first half of the victim search, lookup and second half,
// commit) before its result is loaded. The flush walk loads one result per cycle
// while the output register can take it, one per dirty frame or a single one
// when none is dirty. A result waiting in the output register stalls the sequencer.
// Reset clears all frames, use tick and the journal enable register.
`timescale 1ns / 1ps
`default_nettype none
module page_buffer_pool_directory_top #(
	parameter int FRAMES = pbpd_pkg::FRAMES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic journal_we,
	input  wire logic journal_wd,
	pbpd_if.sink      cmd_in,
	pbpd_if.source    res_out
);
	import pbpd_pkg::*;

	logic journal_enable_q;
	req_t req;
	dp_cmd_t cmd;
	dp_sts_t sts;
	rsp_t rsp_dp;

	// The journaling hook register; the user must write it only while idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) journal_enable_q <= 1'b0;
		else if (journal_we) journal_enable_q <= journal_wd;
	end

	pbpd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cmd_in.valid), .in_ready(cmd_in.ready), .in_data(cmd_in.data),
		.req(req), .cmd(cmd), .sts(sts), .rsp_dp(rsp_dp),
		.out_valid(res_out.valid), .out_ready(res_out.ready), .out_data(res_out.data)
	);

	pbpd_datapath #(.FRAMES(FRAMES)) u_dp (
		.clk(clk), .arst_n(arst_n), .journal_enable(journal_enable_q),
		.req(req), .cmd(cmd), .sts(sts), .rsp(rsp_dp)
	);
endmodule
`default_nettype wire

FILE: rtl/pbpd_datapath.sv
// Frame directory datapath: frame state, lookup, victim search, flush scan.
// Depends on pbpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pbpd_datapath #(
	parameter int FRAMES = pbpd_pkg::FRAMES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              journal_enable,
	input  wire pbpd_pkg::req_t    req,
	input  wire pbpd_pkg::dp_cmd_t cmd,
	output pbpd_pkg::dp_sts_t      sts,
	output pbpd_pkg::rsp_t         rsp
);
	import pbpd_pkg::*;
	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	logic [FRAMES-1:0]  valid_q, dirty_q;
	logic [PAGE_W-1:0]  page_q [FRAMES];
	logic [PIN_W-1:0]   pins_q [FRAMES];
	logic [STAMP_W-1:0] stamp_q [FRAMES];
	logic [STAMP_W-1:0] tick_q;

	// Lookup and victim search, registered by the resolve command.
	logic [FRAMES-1:0] match, free, unpinned;
	logic [IW-1:0] hit_idx, free_idx, lru_idx, fl_idx;
	logic found_c, free_c, unp_c;
	logic found_q, vok_q;
	logic [IW-1:0] f_q;

	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			match[i] = valid_q[i] && (page_q[i] == req.page);
			free[i] = !valid_q[i];
			unpinned[i] = (pins_q[i] == '0);
		end
	end

	always_comb begin
		hit_idx = '0;
		free_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (match[i]) hit_idx = IW'(i);
			if (free[i]) free_idx = IW'(i);
		end
		found_c = |match;
		free_c = |free;
		unp_c = |unpinned;
	end

	// Minimum-stamp search across unpinned frames as a tree, lowest index on ties.
	// The levels nearest the leaves are reduced and registered in the search cycle, the
	// remaining levels toward the root in the resolve cycle.
	localparam int LEAVES = 1 << IW;
	localparam int HALF = 1 << (IW / 2);
	logic [STAMP_W-1:0] t_st [2*LEAVES];
	logic [IW-1:0]      t_ix [2*LEAVES];
	logic               t_ok [2*LEAVES];
	logic [STAMP_W-1:0] min_st_s1 [HALF];
	logic [IW-1:0]      min_ix_s1 [HALF];
	logic               min_ok_s1 [HALF];
	logic [STAMP_W-1:0] u_st [2*HALF];
	logic [IW-1:0]      u_ix [2*HALF];
	logic               u_ok [2*HALF];

	always_comb begin
		for (int n = 0; n < 2*LEAVES; n++) begin
			t_st[n] = '0; t_ix[n] = '0; t_ok[n] = 1'b0;
		end
		for (int i = 0; i < LEAVES; i++) begin
			t_st[LEAVES+i] = (i < FRAMES) ? stamp_q[i % FRAMES] : '0;
			t_ix[LEAVES+i] = IW'(i);
			t_ok[LEAVES+i] = (i < FRAMES) ? unpinned[i % FRAMES] : 1'b0;
		end
		for (int n = LEAVES - 1; n >= HALF; n--) begin
			if (t_ok[2*n] && (!t_ok[2*n+1] || t_st[2*n] <= t_st[2*n+1])) begin
				t_st[n] = t_st[2*n]; t_ix[n] = t_ix[2*n]; t_ok[n] = t_ok[2*n];
			end else begin
				t_st[n] = t_st[2*n+1]; t_ix[n] = t_ix[2*n+1]; t_ok[n] = t_ok[2*n+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < HALF; j++) begin
				min_st_s1[j] <= '0;
				min_ix_s1[j] <= '0;
				min_ok_s1[j] <= 1'b0;
			end
		end else if (cmd.search) begin
			for (int j = 0; j < HALF; j++) begin
				min_st_s1[j] <= t_st[HALF+j];
				min_ix_s1[j] <= t_ix[HALF+j];
				min_ok_s1[j] <= t_ok[HALF+j];
			end
		end
	end

	always_comb begin
		u_st[0] = '0; u_ix[0] = '0; u_ok[0] = 1'b0;
		for (int j = 0; j < HALF; j++) begin
			u_st[HALF+j] = min_st_s1[j];
			u_ix[HALF+j] = min_ix_s1[j];
			u_ok[HALF+j] = min_ok_s1[j];
		end
		for (int n = HALF - 1; n >= 1; n--) begin
			if (u_ok[2*n] && (!u_ok[2*n+1] || u_st[2*n] <= u_st[2*n+1])) begin
				u_st[n] = u_st[2*n]; u_ix[n] = u_ix[2*n]; u_ok[n] = u_ok[2*n];
			end else begin
				u_st[n] = u_st[2*n+1]; u_ix[n] = u_ix[2*n+1]; u_ok[n] = u_ok[2*n+1];
			end
		end
		lru_idx = u_ix[1];
	end

	// Flush scan: lowest dirty valid frame, and whether another follows.
	logic [FRAMES-1:0] dv, dv_rest;
	always_comb begin
		dv = valid_q & dirty_q;
		fl_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--)
			if (dv[i]) fl_idx = IW'(i);
		dv_rest = dv;
		dv_rest[fl_idx] = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			vok_q <= 1'b0;
			f_q <= '0;
		end else if (cmd.resolve) begin
			found_q <= found_c;
			vok_q <= free_c || unp_c;
			f_q <= found_c ? hit_idx : (free_c ? free_idx : lru_idx);
		end
	end

	assign sts.found = found_q;
	assign sts.victim_ok = vok_q;
	assign sts.flush_any = |dv;
	assign sts.flush_more = |dv_rest;

	logic wr;
	logic wb_c, dirty_after_load, jr_c;
	assign wr = (req.command == CMD_GET_WR);
	assign wb_c = !found_q && valid_q[f_q] && dirty_q[f_q];
	assign dirty_after_load = found_q ? dirty_q[f_q] : 1'b0;
	assign jr_c = wr && journal_enable && !dirty_after_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			tick_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				page_q[i] <= '0;
				pins_q[i] <= '0;
				stamp_q[i] <= '0;
			end
		end else begin
			if (cmd.do_get) begin
				valid_q[f_q] <= 1'b1;
				dirty_q[f_q] <= wr ? 1'b1 : dirty_after_load;
				if (!found_q) begin
					page_q[f_q] <= req.page;
					pins_q[f_q] <= PIN_W'(1);
					stamp_q[f_q] <= tick_q + STAMP_W'(2);
					tick_q <= tick_q + STAMP_W'(2);
				end else begin
					if (pins_q[f_q] != '1) pins_q[f_q] <= pins_q[f_q] + PIN_W'(1);
					stamp_q[f_q] <= tick_q + STAMP_W'(1);
					tick_q <= tick_q + STAMP_W'(1);
				end
			end
			if (cmd.do_unpin && found_q && pins_q[f_q] != '0)
				pins_q[f_q] <= pins_q[f_q] - PIN_W'(1);
			if (cmd.flush_step)
				dirty_q[fl_idx] <= 1'b0;
			if (cmd.do_discard) begin
				valid_q <= '0;
				dirty_q <= '0;
				for (int i = 0; i < FRAMES; i++) pins_q[i] <= '0;
			end
		end
	end

	// Result fields for whichever command the controller is finishing.
	always_comb begin
		rsp = '0;
		rsp.last = 1'b1;
		if (cmd.do_get) begin
			rsp.frame = FRAME_W'(f_q);
			rsp.hit = found_q;
			rsp.fetch = !found_q;
			rsp.writeback = wb_c;
			rsp.writeback_page = wb_c ? page_q[f_q] : '0;
			rsp.journal = jr_c;
		end else if (cmd.do_unpin) begin
			rsp.frame = found_q ? FRAME_W'(f_q) : '0;
			rsp.hit = found_q;
			rsp.status = found_q ? ST_OK : ST_NOT_RESIDENT;
		end else if (cmd.flush_step) begin
			rsp.frame = FRAME_W'(fl_idx);
			rsp.writeback = 1'b1;
			rsp.writeback_page = page_q[fl_idx];
			rsp.last = !(|dv_rest);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/pbpd_ctrl.sv
// Command sequencer: accepts an item, runs lookup/commit or the flush walk,
// and loads the output register. Depends on pbpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pbpd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pbpd_pkg::req_t    in_data,
	output pbpd_pkg::req_t         req,
	output pbpd_pkg::dp_cmd_t      cmd,
	input  wire pbpd_pkg::dp_sts_t sts,
	input  wire pbpd_pkg::rsp_t    rsp_dp,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pbpd_pkg::rsp_t         out_data
);
	import pbpd_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_RESOLVE = 3'd2;
	localparam logic [2:0] S_EXEC = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0] state_q;
	req_t req_q;
	logic ovalid_q;
	rsp_t odata_q;
	logic slot_free, emit;
	rsp_t emit_data;

	assign req = req_q;
	assign in_ready = (state_q == S_IDLE);
	assign slot_free = !ovalid_q || out_ready;
	assign out_valid = ovalid_q;
	assign out_data = odata_q;

	always_comb begin
		cmd = '0;
		emit = 1'b0;
		emit_data = rsp_dp;
		unique case (state_q)
			S_SEARCH: cmd.search = 1'b1;
			S_RESOLVE: cmd.resolve = 1'b1;
			S_EXEC: if (slot_free) begin
				emit = 1'b1;
				if (req_q.command == CMD_GET || req_q.command == CMD_GET_WR) begin
					if (sts.found || sts.victim_ok) cmd.do_get = 1'b1;
					else begin
						emit_data = '0;
						emit_data.status = ST_EXHAUSTED;
						emit_data.last = 1'b1;
					end
				end else if (req_q.command == CMD_UNPIN) begin
					cmd.do_unpin = 1'b1;
				end else if (req_q.command == CMD_DISCARD) begin
					cmd.do_discard = 1'b1;
				end
			end
			S_FLUSH: if (slot_free) begin
				emit = 1'b1;
				if (sts.flush_any) cmd.flush_step = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (emit) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid)
					state_q <= (in_data.command == CMD_FLUSH) ? S_FLUSH : S_SEARCH;
				S_SEARCH: state_q <= S_RESOLVE;
				S_RESOLVE: state_q <= S_EXEC;
				S_EXEC: if (emit) state_q <= S_IDLE;
				S_FLUSH: if (emit && !(sts.flush_any && sts.flush_more)) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) req_q <= in_data;
		if (emit) odata_q <= emit_data;
	end
endmodule
`default_nettype wire
